[hw/rtl/tcc_pkg.sv]
// Text console package: field widths, operation and character codes,
// configuration layout and controller state encoding.
// No dependencies.
package tcc_pkg;

    localparam int OP_W       = 3;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int SCROLL_W   = 6;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
    localparam logic [OP_W-1:0] OP_PLACE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SCROLL = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR    = 2'd2;

    localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;
    localparam logic [ROW_W-1:0]  ROWS_RESET = 5'd25;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    typedef struct packed {
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  rows;
        logic [ATTR_W-1:0] attr;
    } tcc_cfg_t;

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_START = 7'b0000100,
        ST_COPY  = 7'b0001000,
        ST_BLANK = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } tcc_state_t;

endpackage

[hw/rtl/tcc_cmd_if.sv]
// Command channel of the text console: valid/ready plus one operation.
// Depends on tcc_pkg.
interface tcc_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [tcc_pkg::OP_W-1:0]              operation;
    logic [tcc_pkg::CHAR_W-1:0]            char_code;
    logic [tcc_pkg::COL_W-1:0]             column;
    logic [tcc_pkg::ROW_W-1:0]             row;
    logic signed [tcc_pkg::SCROLL_W-1:0]   scroll_lines;

    modport source (output valid, operation, char_code, column, row, scroll_lines,
                    input ready);
    modport sink   (input valid, operation, char_code, column, row, scroll_lines,
                    output ready);
endinterface

[hw/rtl/tcc_rsp_if.sv]
// Response channel of the text console: cursor, cell word and error flag.
// Depends on tcc_pkg.
interface tcc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tcc_pkg::COL_W-1:0]    cursor_column;
    logic [tcc_pkg::ROW_W-1:0]    cursor_row;
    logic [tcc_pkg::CELL_W-1:0]   cell_word;
    logic                         bad_position;

    modport source (output valid, cursor_column, cursor_row, cell_word, bad_position,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_row, cell_word, bad_position,
                     output ready);
endinterface

[hw/rtl/tcc_cfg_regs.sv]
// Configuration registers of the text console with the active-size clamp.
// Depends on tcc_pkg.
module tcc_cfg_regs #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]     index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]    wdata,
    output tcc_pkg::tcc_cfg_t                 cfg
);
    import tcc_pkg::*;

    logic [COL_W-1:0]  cols_reg;
    logic [ROW_W-1:0]  rows_reg;
    logic [ATTR_W-1:0] attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            attr_reg <= ATTR_RESET;
        end
        else if (we)
        begin
            unique case (index)
                REG_COLUMNS: cols_reg <= wdata[COL_W-1:0];
                REG_ROWS:    rows_reg <= wdata[ROW_W-1:0];
                REG_ATTR:    attr_reg <= wdata[ATTR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        if (cols_reg == '0)
            cfg.cols = COL_W'(1);
        else if (int'(cols_reg) > MAX_COLUMNS)
            cfg.cols = COL_W'(MAX_COLUMNS);
        else
            cfg.cols = cols_reg;

        if (rows_reg == '0)
            cfg.rows = ROW_W'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            cfg.rows = ROW_W'(MAX_ROWS);
        else
            cfg.rows = rows_reg;

        cfg.attr = attr_reg;
    end

endmodule

[hw/rtl/tcc_screen_mem.sv]
// Screen cell store: one write port, one read port with registered data.
// Depends on tcc_pkg.
module tcc_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tcc_pkg::CELL_W-1:0]   wdata,
    input  logic [AW-1:0]                raddr,
    output logic [tcc_pkg::CELL_W-1:0]   rdata
);
    import tcc_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/text_console_cursor_scroll_core.sv]
// Text console core: controller, cursor and scroll/clear walker around the
// screen store. Depends on tcc_pkg, tcc_cmd_if, tcc_rsp_if, tcc_cfg_regs,
// tcc_screen_mem.
//
// Usage: one command beat on cmd gives exactly one response beat on rsp.
// cfg_we/cfg_index/cfg_wdata write the active column count, active row
// count and cell attribute; write them only while no command is in flight.
// Command paths, accept to response loaded:
//   put (CR, LF or plain character without scroll), place, zero scroll,
//   unused codes: straight to the done state
//   read cell: through the read state, for the registered store read
//   LF or wrap at the bottom row, FF, nonzero scroll, clear: through the start
//   state and a walk of the active screen; the walker moves or blanks one cell per
//   cycle through the single store write port.
// After reset the store is cleared to space/attribute 7, one cell a cycle;
// cmd.ready stays low meanwhile while configuration writes are taken.
// A response waits in its own register; the next command is accepted while
// it waits, and a second result stalls in the done state until rsp.ready.
module text_console_cursor_scroll_core #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tcc_cmd_if.sink                           cmd,
    tcc_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tcc_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
        cell_addr = AW'(int'(r) * MAX_COLUMNS + int'(c));
    endfunction

    tcc_cfg_t cfg;

    tcc_state_t        state_reg, state_next;
    logic [AW-1:0]     init_addr_reg, init_addr_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  n_reg, n_next;
    logic              up_reg, up_next;
    logic [ROW_W-1:0]  wrow_reg, wrow_next;
    logic [ROW_W-1:0]  wcnt_reg, wcnt_next;
    logic [COL_W-1:0]  wcol_reg, wcol_next;
    logic              pw_valid_reg, pw_valid_next;
    logic [AW-1:0]     pw_addr_reg, pw_addr_next;
    logic              pw_mem_reg, pw_mem_next;
    logic [CELL_W-1:0] pw_data_reg, pw_data_next;
    logic              inside_reg, inside_next;
    logic              bad_reg, bad_next;
    logic [CELL_W-1:0] word_reg, word_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [COL_W-1:0]  rsp_col_reg, rsp_col_next;
    logic [ROW_W-1:0]  rsp_row_reg, rsp_row_next;
    logic [CELL_W-1:0] rsp_word_reg, rsp_word_next;
    logic              rsp_bad_reg, rsp_bad_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic [COL_W-1:0]    cc;
    logic [ROW_W-1:0]    cr;
    logic                cmd_inside;
    logic                at_last_row;
    logic                col_wrap;
    logic [SCROLL_W-1:0] sl_bits;
    logic [SCROLL_W-1:0] scroll_mag;
    logic [ROW_W-1:0]    scroll_n;
    logic [ROW_W-1:0]    copy_rows;
    logic [ROW_W-1:0]    blank_start;
    logic                wcol_last;
    logic [ROW_W-1:0]    src_row;
    logic [CELL_W-1:0]   blank_cell;

    tcc_cfg_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    tcc_screen_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // cursor clamped into the active screen
    assign cc          = (cur_col_reg >= cfg.cols) ? cfg.cols - COL_W'(1) : cur_col_reg;
    assign cr          = (cur_row_reg >= cfg.rows) ? cfg.rows - ROW_W'(1) : cur_row_reg;
    assign cmd_inside  = (cmd.column < cfg.cols) && (cmd.row < cfg.rows);
    assign at_last_row = ({1'b0, cr} + (ROW_W+1)'(1)) >= {1'b0, cfg.rows};
    assign col_wrap    = ({1'b0, cc} + (COL_W+1)'(1)) >= {1'b0, cfg.cols};
    assign sl_bits     = cmd.scroll_lines;
    assign scroll_mag  = sl_bits[SCROLL_W-1] ? (SCROLL_W'(0) - sl_bits) : sl_bits;
    assign scroll_n    = (scroll_mag > {1'b0, cfg.rows}) ? cfg.rows : scroll_mag[ROW_W-1:0];
    assign copy_rows   = cfg.rows - n_reg;
    assign blank_start = up_reg ? copy_rows : '0;
    assign wcol_last   = (wcol_reg == cfg.cols - COL_W'(1));
    assign src_row     = up_reg ? wrow_reg + n_reg : wrow_reg - n_reg;
    assign blank_cell  = {cfg.attr, CH_SPACE};

    assign mem_we    = (state_reg == ST_INIT) || pw_valid_reg;
    assign mem_waddr = (state_reg == ST_INIT) ? init_addr_reg : pw_addr_reg;
    assign mem_wdata = (state_reg == ST_INIT) ? CELL_RESET
                     : (pw_mem_reg ? mem_rdata : pw_data_reg);

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_column = rsp_col_reg;
    assign rsp.cursor_row    = rsp_row_reg;
    assign rsp.cell_word     = rsp_word_reg;
    assign rsp.bad_position  = rsp_bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        n_next         = n_reg;
        up_next        = up_reg;
        wrow_next      = wrow_reg;
        wcnt_next      = wcnt_reg;
        wcol_next      = wcol_reg;
        pw_valid_next  = 1'b0;
        pw_addr_next   = pw_addr_reg;
        pw_mem_next    = pw_mem_reg;
        pw_data_next   = pw_data_reg;
        inside_next    = inside_reg;
        bad_next       = bad_reg;
        word_next      = word_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_bad_next   = rsp_bad_reg;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                init_addr_next = init_addr_reg + AW'(1);
                if (init_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                mem_raddr = cell_addr(cmd.row, cmd.column);
                if (cmd.valid)
                begin
                    cur_col_next = cc;
                    cur_row_next = cr;
                    bad_next     = 1'b0;
                    word_next    = '0;
                    state_next   = ST_DONE;
                    case (cmd.operation)
                        OP_PUT:
                        begin
                            if (cmd.char_code == CH_CR)
                                cur_col_next = '0;
                            else if (cmd.char_code == CH_LF)
                            begin
                                if (at_last_row)
                                begin
                                    up_next    = 1'b1;
                                    n_next     = ROW_W'(1);
                                    state_next = ST_START;
                                end
                                else
                                    cur_row_next = cr + ROW_W'(1);
                            end
                            else if (cmd.char_code == CH_FF)
                            begin
                                cur_col_next = '0;
                                cur_row_next = '0;
                                up_next      = 1'b0;
                                n_next       = cfg.rows;
                                state_next   = ST_START;
                            end
                            else
                            begin
                                pw_valid_next = 1'b1;
                                pw_addr_next  = cell_addr(cr, cc);
                                pw_mem_next   = 1'b0;
                                pw_data_next  = {cfg.attr, cmd.char_code};
                                if (col_wrap)
                                begin
                                    cur_col_next = '0;
                                    if (at_last_row)
                                    begin
                                        up_next    = 1'b1;
                                        n_next     = ROW_W'(1);
                                        state_next = ST_START;
                                    end
                                    else
                                        cur_row_next = cr + ROW_W'(1);
                                end
                                else
                                    cur_col_next = cc + COL_W'(1);
                            end
                        end
                        OP_PLACE:
                        begin
                            if (cmd_inside)
                            begin
                                pw_valid_next = 1'b1;
                                pw_addr_next  = cell_addr(cmd.row, cmd.column);
                                pw_mem_next   = 1'b0;
                                pw_data_next  = {cfg.attr, cmd.char_code};
                            end
                            else
                                bad_next = 1'b1;
                        end
                        OP_SCROLL:
                        begin
                            if (scroll_mag != '0)
                            begin
                                up_next    = !sl_bits[SCROLL_W-1];
                                n_next     = scroll_n;
                                state_next = ST_START;
                            end
                        end
                        OP_CLEAR:
                        begin
                            up_next    = 1'b0;
                            n_next     = cfg.rows;
                            state_next = ST_START;
                        end
                        OP_READ:
                        begin
                            inside_next = cmd_inside;
                            bad_next    = !cmd_inside;
                            state_next  = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            // the start state lets a pending cell write land before the walk reads
            ST_START:
            begin
                wcol_next = '0;
                if (copy_rows == '0)
                begin
                    wrow_next  = blank_start;
                    wcnt_next  = n_reg;
                    state_next = ST_BLANK;
                end
                else
                begin
                    wrow_next  = up_reg ? '0 : cfg.rows - ROW_W'(1);
                    wcnt_next  = copy_rows;
                    state_next = ST_COPY;
                end
            end

            ST_COPY:
            begin
                mem_raddr     = cell_addr(src_row, wcol_reg);
                pw_valid_next = 1'b1;
                pw_addr_next  = cell_addr(wrow_reg, wcol_reg);
                pw_mem_next   = 1'b1;
                if (wcol_last)
                begin
                    wcol_next = '0;
                    if (wcnt_reg == ROW_W'(1))
                    begin
                        wrow_next  = blank_start;
                        wcnt_next  = n_reg;
                        state_next = ST_BLANK;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg - ROW_W'(1);
                        wrow_next = up_reg ? wrow_reg + ROW_W'(1) : wrow_reg - ROW_W'(1);
                    end
                end
                else
                    wcol_next = wcol_reg + COL_W'(1);
            end

            ST_BLANK:
            begin
                pw_valid_next = 1'b1;
                pw_addr_next  = cell_addr(wrow_reg, wcol_reg);
                pw_mem_next   = 1'b0;
                pw_data_next  = blank_cell;
                if (wcol_last)
                begin
                    wcol_next = '0;
                    if (wcnt_reg == ROW_W'(1))
                        state_next = ST_DONE;
                    else
                    begin
                        wcnt_next = wcnt_reg - ROW_W'(1);
                        wrow_next = wrow_reg + ROW_W'(1);
                    end
                end
                else
                    wcol_next = wcol_reg + COL_W'(1);
            end

            ST_READ:
            begin
                word_next  = inside_reg ? mem_rdata : '0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_col_next   = cur_col_reg;
                    rsp_row_next   = cur_row_reg;
                    rsp_word_next  = word_reg;
                    rsp_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            pw_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            pw_valid_reg  <= pw_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        up_reg       <= up_next;
        wrow_reg     <= wrow_next;
        wcnt_reg     <= wcnt_next;
        wcol_reg     <= wcol_next;
        pw_addr_reg  <= pw_addr_next;
        pw_mem_reg   <= pw_mem_next;
        pw_data_reg  <= pw_data_next;
        inside_reg   <= inside_next;
        bad_reg      <= bad_next;
        word_reg     <= word_next;
        rsp_col_reg  <= rsp_col_next;
        rsp_row_reg  <= rsp_row_next;
        rsp_word_reg <= rsp_word_next;
        rsp_bad_reg  <= rsp_bad_next;
    end

endmodule

[hw/rtl/tcc_checker.sv]
// Port-level checks of the text console core, attached by bind.
// Depends on text_console_cursor_scroll_core and tcc_pkg.
module tcc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [tcc_pkg::COL_W-1:0]   rsp_col,
    input logic [tcc_pkg::ROW_W-1:0]   rsp_row,
    input logic [tcc_pkg::CELL_W-1:0]  rsp_word,
    input logic                        rsp_bad
);
    import tcc_pkg::*;

    logic [1:0] outstanding_reg;
    logic       cmd_beat;
    logic       rsp_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_reg + 2'(cmd_beat) - 2'(rsp_beat);
    end

    a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat |=> !cmd_ready)
        else $error("command accepted back to back");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable(rsp_col) && $stable(rsp_row) && $stable(rsp_word)
            && $stable(rsp_bad))
        else $error("stalled response changed");

    a_bad_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bad |-> rsp_word == '0)
        else $error("bad position with nonzero cell word");

    a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("response beat without a command");

    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg != 2'd3)
        else $error("too many commands in flight");

endmodule

bind text_console_cursor_scroll_core tcc_checker u_tcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_col   (rsp.cursor_column),
    .rsp_row   (rsp.cursor_row),
    .rsp_word  (rsp.cell_word),
    .rsp_bad   (rsp.bad_position)
);

[tb/sv/tb_text_console_cursor_scroll_core.sv]
`timescale 1ns / 100ps
// Self-checking bench for text_console_cursor_scroll_core: directed and random console
// commands against a behavioral screen/cursor predictor. Depends on tcc_pkg, tcc_cmd_if,
// tcc_rsp_if and the core RTL.
module tb_text_console_cursor_scroll_core;
    import tcc_pkg::*;

    localparam int MAX_COLS  = 80;
    localparam int MAX_ROWS  = 25;
    localparam int HOLD_AT   = 100;
    localparam int HOLD_LEN  = 400;
    localparam int DRAIN_CYC = 2100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic [CHAR_W-1:0]          char_code;
        logic [COL_W-1:0]           column;
        logic [ROW_W-1:0]           row;
        logic signed [SCROLL_W-1:0] scroll_lines;
    } console_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_word;
        logic              bad_position;
    } console_rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tcc_cmd_if cmd_ch ();
    tcc_rsp_if rsp_ch ();

    text_console_cursor_scroll_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted screen, cursor and register copies
    logic [CELL_W-1:0] screen [MAX_COLS*MAX_ROWS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [COL_W-1:0]  cfg_cols;
    logic [ROW_W-1:0]  cfg_rows;
    logic [ATTR_W-1:0] cfg_attr;

    console_cmd_t commands_to_send [$];
    console_rsp_t responses_due [$];

    int  cmds_issued   = 0;
    int  cmds_accepted = 0;
    int  errors        = 0;
    int  off_screen    = 0;
    int  settings_run  = 0;
    int  op_count [8];
    bit  idle_on       = 1'b1;
    bit  cmd_taken     = 1'b0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    console_cmd_t seen_cmd;
    console_rsp_t due_rsp;
    console_cmd_t next_cmd;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("%0t: timeout, %0d of %0d commands accepted", $time, cmds_accepted,
                 cmds_issued);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic int unsigned active_cols();
        if (cfg_cols < 1) return 1;
        if (cfg_cols > MAX_COLS) return MAX_COLS;
        return cfg_cols;
    endfunction

    function automatic int unsigned active_rows();
        if (cfg_rows < 1) return 1;
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return cfg_rows;
    endfunction

    task automatic screen_reset();
        foreach (screen[i])
            screen[i] = CELL_RESET;
        cur_col  = 0;
        cur_row  = 0;
        cfg_cols = COLS_RESET;
        cfg_rows = ROWS_RESET;
        cfg_attr = ATTR_RESET;
    endtask

    task automatic blank_row(input int unsigned r);
        int unsigned c;
        for (c = 0; c < active_cols(); c++)
            screen[r*MAX_COLS + c] = {cfg_attr, CH_SPACE};
    endtask

    task automatic blank_screen();
        int unsigned r;
        for (r = 0; r < active_rows(); r++)
            blank_row(r);
    endtask

    task automatic shift_rows(input bit up, input int unsigned n);
        int unsigned rows;
        int unsigned y;
        int unsigned c;
        rows = active_rows();
        if (n == 0)
            return;
        if (n > rows)
            n = rows;
        if (up)
        begin
            for (y = 0; y + n < rows; y++)
                for (c = 0; c < active_cols(); c++)
                    screen[y*MAX_COLS + c] = screen[(y+n)*MAX_COLS + c];
            for (y = rows - n; y < rows; y++)
                blank_row(y);
        end
        else
        begin
            for (y = rows; y > n; y--)
                for (c = 0; c < active_cols(); c++)
                    screen[(y-1)*MAX_COLS + c] = screen[(y-1-n)*MAX_COLS + c];
            for (y = 0; y < n; y++)
                blank_row(y);
        end
    endtask

    task automatic line_feed();
        cur_row++;
        if (cur_row >= active_rows())
        begin
            cur_row = active_rows() - 1;
            shift_rows(1'b1, 1);
        end
    endtask

    task automatic console_apply(input console_cmd_t c, output console_rsp_t r);
        int unsigned cols;
        int unsigned rows;
        bit          on_screen;
        int          lines;
        cols      = active_cols();
        rows      = active_rows();
        on_screen = (c.column < cols) && (c.row < rows);
        r         = '0;
        if (cur_col >= cols)
            cur_col = cols - 1;
        if (cur_row >= rows)
            cur_row = rows - 1;
        case (c.operation)
            OP_PUT:
            begin
                if (c.char_code == CH_CR)
                    cur_col = 0;
                else if (c.char_code == CH_LF)
                    line_feed();
                else if (c.char_code == CH_FF)
                begin
                    cur_col = 0;
                    cur_row = 0;
                    blank_screen();
                end
                else
                begin
                    screen[cur_row*MAX_COLS + cur_col] = {cfg_attr, c.char_code};
                    cur_col++;
                    if (cur_col >= cols)
                    begin
                        cur_col = 0;
                        line_feed();
                    end
                end
            end
            OP_PLACE:
            begin
                if (on_screen)
                    screen[c.row*MAX_COLS + c.column] = {cfg_attr, c.char_code};
                else
                    r.bad_position = 1'b1;
            end
            OP_SCROLL:
            begin
                lines = $signed(c.scroll_lines);
                if (lines < 0)
                    shift_rows(1'b0, -lines);
                else
                    shift_rows(1'b1, lines);
            end
            OP_CLEAR:
                blank_screen();
            OP_READ:
            begin
                if (on_screen)
                    r.cell_word = screen[c.row*MAX_COLS + c.column];
                else
                    r.bad_position = 1'b1;
            end
            default:
                ;
        endcase
        r.cursor_column = cur_col[COL_W-1:0];
        r.cursor_row    = cur_row[ROW_W-1:0];
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic console_cmd_t make_cmd(input int op,
                                              input int ch,
                                              input int col,
                                              input int row,
                                              input int lines);
        console_cmd_t c;
        c.operation    = OP_W'(op);
        c.char_code    = CHAR_W'(ch);
        c.column       = COL_W'(col);
        c.row          = ROW_W'(row);
        c.scroll_lines = SCROLL_W'(lines);
        return c;
    endfunction

    function automatic console_cmd_t random_command();
        console_cmd_t c;
        int unsigned  cols;
        int unsigned  rows;
        int unsigned  sel;
        int unsigned  pick;
        cols = active_cols();
        rows = active_rows();
        c.char_code = CHAR_W'($urandom_range(0, 255));
        c.column = COL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, cols - 1));
        c.row    = ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, rows - 1));
        if ($urandom_range(0, 4) == 0)
            c.scroll_lines = SCROLL_W'($urandom_range(0, 63));
        else
            c.scroll_lines = SCROLL_W'(int'($urandom_range(0, 2*rows)) - int'(rows));
        sel = $urandom_range(0, 99);
        if (sel < 46)
        begin
            c.operation = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                c.char_code = CH_CR;
            else if (pick < 16)
                c.char_code = CH_LF;
            else if (pick < 17)
                c.char_code = CH_FF;
        end
        else if (sel < 64)
            c.operation = OP_PLACE;
        else if (sel < 88)
            c.operation = OP_READ;
        else if (sel < 95)
            c.operation = OP_SCROLL;
        else if (sel < 97)
            c.operation = OP_CLEAR;
        else
            c.operation = OP_W'(int'(OP_READ) + int'($urandom_range(1, 3)));
        return c;
    endfunction

    task automatic post_command(input console_cmd_t c);
        commands_to_send.push_back(c);
        cmds_issued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_COLUMNS: cfg_cols = val[COL_W-1:0];
            REG_ROWS:    cfg_rows = val[ROW_W-1:0];
            REG_ATTR:    cfg_attr = val;
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input int cols, input int rows, input int attr);
        write_reg(REG_COLUMNS, CFG_DATA_W'(cols));
        write_reg(REG_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_ATTR, CFG_DATA_W'(attr));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
        settings_run++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (cmds_accepted != cmds_issued || responses_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // ---------------- command driver ----------------

    always @(negedge clk)
    begin
        if (rst_n && (cmd_taken || !cmd_ch.valid))
        begin
            if (cmd_taken && idle_on && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 15);
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (commands_to_send.size() > 0)
            begin
                next_cmd = commands_to_send.pop_front();
                cmd_ch.valid        <= 1'b1;
                cmd_ch.operation    <= next_cmd.operation;
                cmd_ch.char_code    <= next_cmd.char_code;
                cmd_ch.column       <= next_cmd.column;
                cmd_ch.row          <= next_cmd.row;
                cmd_ch.scroll_lines <= next_cmd.scroll_lines;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // ---------------- response ready, with one long hold-off ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && cmds_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ---------------- monitor and checker ----------------

    function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
                                        input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_cmd.operation    = cmd_ch.operation;
                seen_cmd.char_code    = cmd_ch.char_code;
                seen_cmd.column       = cmd_ch.column;
                seen_cmd.row          = cmd_ch.row;
                seen_cmd.scroll_lines = cmd_ch.scroll_lines;
                console_apply(seen_cmd, due_rsp);
                responses_due.push_back(due_rsp);
                op_count[seen_cmd.operation]++;
                if (due_rsp.bad_position)
                    off_screen++;
                cmds_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (responses_due.size() == 0)
                begin
                    $display("%0t: response beat with nothing due, actual col %0d row %0d",
                             $time, rsp_ch.cursor_column, rsp_ch.cursor_row);
                    errors++;
                end
                else
                begin
                    due_rsp = responses_due.pop_front();
                    check_field("cursor_column", CELL_W'(due_rsp.cursor_column),
                                CELL_W'(rsp_ch.cursor_column));
                    check_field("cursor_row", CELL_W'(due_rsp.cursor_row),
                                CELL_W'(rsp_ch.cursor_row));
                    check_field("cell_word", due_rsp.cell_word, rsp_ch.cell_word);
                    check_field("bad_position", CELL_W'(due_rsp.bad_position),
                                CELL_W'(rsp_ch.bad_position));
                end
            end
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        int p;
        int k;
        int n_items;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_PUT;
        cmd_ch.char_code    = '0;
        cmd_ch.column       = '0;
        cmd_ch.row          = '0;
        cmd_ch.scroll_lines = '0;
        rsp_ch.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_COLUMNS;
        cfg_wdata           = '0;
        rst_n               = 1'b0;
        foreach (op_count[i])
            op_count[i] = 0;
        screen_reset();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset screen, edges of the store, every operation
        post_command(make_cmd(OP_READ, 8'h00, 0, 0, 0));
        post_command(make_cmd(OP_READ, 8'h00, MAX_COLS-1, MAX_ROWS-1, 0));
        post_command(make_cmd(OP_READ, 8'h00, MAX_COLS, 0, 0));
        post_command(make_cmd(OP_READ, 8'h00, 0, MAX_ROWS, 0));
        post_command(make_cmd(OP_PLACE, 8'hFF, MAX_COLS-1, MAX_ROWS-1, 0));
        post_command(make_cmd(OP_READ, 8'h00, MAX_COLS-1, MAX_ROWS-1, 0));
        post_command(make_cmd(OP_PLACE, 8'h41, 127, 31, 0));
        post_command(make_cmd(OP_READ, 8'h00, 127, 31, 0));
        post_command(make_cmd(OP_PUT, 8'h48, 0, 0, 0));
        post_command(make_cmd(OP_PUT, 8'h00, 0, 0, 0));
        post_command(make_cmd(OP_PUT, CH_CR, 0, 0, 0));
        post_command(make_cmd(OP_PUT, CH_LF, 0, 0, 0));
        post_command(make_cmd(OP_READ, 8'h00, 1, 0, 0));
        post_command(make_cmd(OP_SCROLL, 8'h00, 0, 0, 1));
        post_command(make_cmd(OP_READ, 8'h00, MAX_COLS-1, MAX_ROWS-2, 0));
        post_command(make_cmd(OP_SCROLL, 8'h00, 0, 0, -1));
        post_command(make_cmd(OP_SCROLL, 8'h00, 0, 0, 0));
        post_command(make_cmd(OP_SCROLL, 8'h00, 0, 0, 31));
        post_command(make_cmd(OP_PLACE, 8'h7E, 3, 3, 0));
        post_command(make_cmd(OP_SCROLL, 8'h00, 0, 0, -32));
        post_command(make_cmd(OP_PUT, CH_FF, 0, 0, 0));
        post_command(make_cmd(OP_CLEAR, 8'h00, 0, 0, 0));
        for (k = 1; k <= 3; k++)
            post_command(make_cmd(int'(OP_READ) + k, 8'h55, 5, 5, 0));
        wait_quiet();

        // random phases; small screens mostly, out-of-range sizes and full size a few times
        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:       set_screen(8, 4, $urandom_range(0, 255));
                1:       set_screen(0, 0, 8'hFF);
                2:       set_screen(8'hFF, 8'hFF, 8'h00);
                9:       set_screen(MAX_COLS, MAX_ROWS, $urandom_range(0, 255));
                default: set_screen($urandom_range(1, 16), $urandom_range(1, 8),
                                    $urandom_range(0, 255));
            endcase
            idle_on = (p != 4) && (p != 9);
            n_items = (p == 2 || p == 9) ? 60 : 200;
            for (k = 0; k < n_items; k++)
                post_command(random_command());
            wait_quiet();
        end

        repeat (DRAIN_CYC) @(negedge clk);
        $display("Covered %0d commands: %0d put, %0d place, %0d read, %0d scroll, %0d clear,",
                 cmds_accepted, op_count[OP_PUT], op_count[OP_PLACE], op_count[OP_READ],
                 op_count[OP_SCROLL], op_count[OP_CLEAR]);
        $display("  %0d unused codes, %0d off-screen positions, %0d screen settings.",
                 cmds_accepted - op_count[OP_PUT] - op_count[OP_PLACE] - op_count[OP_READ]
                 - op_count[OP_SCROLL] - op_count[OP_CLEAR], off_screen, settings_run);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[text_console_cursor_scroll_core.f]
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_cmd_if.sv
hw/rtl/tcc_rsp_if.sv
hw/rtl/tcc_cfg_regs.sv
hw/rtl/tcc_screen_mem.sv
hw/rtl/text_console_cursor_scroll_core.sv
hw/rtl/tcc_checker.sv
tb/sv/tb_text_console_cursor_scroll_core.sv
